[rtl/core/assert_macros.svh]
// assertion macros of the sha1 engine rtl, used in sha1_ctrl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define SHA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sha1 engine assertion failed");
`define SHA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sha1 engine assertion failed");
`else
`define SHA_ASSERT(lbl, clk, rst_n, prop)
`define SHA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[rtl/core/sha1_pkg.sv]
// types, constants and helpers of the sha1 engine
`timescale 1ns / 1ps
package sha1_pkg;

  typedef logic [31:0] word_t;
  typedef logic [4:0][31:0] chain_t;

  // control from the sequencer to the round datapath
  typedef struct packed {
    logic       load;
    logic       step;
    logic       fin;
    logic       iv;
    logic [6:0] rnd;
  } rnd_ctl_t;

  // initial vector, element 0 is word a
  localparam chain_t IV = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                           32'hEFCDAB89, 32'h67452301};

  localparam word_t K0 = 32'h5A827999;
  localparam word_t K1 = 32'h6ED9EBA1;
  localparam word_t K2 = 32'h8F1BBCDC;
  localparam word_t K3 = 32'hCA62C1D6;

  // round boundaries
  localparam logic [6:0] RND_F1      = 7'd20;
  localparam logic [6:0] RND_F2      = 7'd40;
  localparam logic [6:0] RND_F3      = 7'd60;
  localparam logic [6:0] RND_LAST    = 7'd79;
  localparam logic [6:0] SCHED_WORDS = 7'd16;

  // schedule memory geometry and read offsets
  localparam int         SCHED_DEPTH = 16;
  localparam int         SCHED_AW    = 4;
  localparam logic [3:0] OFS_M14     = 4'd2;
  localparam logic [3:0] OFS_M3      = 4'd13;
  localparam logic [3:0] OFS_M8      = 4'd8;
  localparam logic [3:0] OFS_NEXT    = 4'd1;
  localparam logic [3:0] OFS_NEXT_M14 = 4'd3;

  // byte stream and padding
  localparam logic [7:0]  PAD_MARK      = 8'h80;
  localparam logic [7:0]  PAD_ZERO      = 8'h00;
  localparam logic [5:0]  LEN_POS       = 6'd56;
  localparam logic [5:0]  FILL_LAST     = 6'd63;
  localparam logic [1:0]  WORD_LAST     = 2'd3;
  localparam logic [63:0] BITS_PER_BYTE = 64'd8;
  localparam logic [2:0]  LAST_IDX      = 3'd4;

  function automatic word_t rotl(input word_t x, input int n);
    rotl = (x << n) | (x >> (32 - n));
  endfunction

endpackage

[rtl/core/sha1_in_if.sv]
// message byte channel
`timescale 1ns / 1ps
interface sha1_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       last;

  modport source (output valid, data_byte, byte_present, last, input ready);
  modport sink   (input valid, data_byte, byte_present, last, output ready);
endinterface

[rtl/core/sha1_out_if.sv]
// digest word channel
`timescale 1ns / 1ps
interface sha1_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        final_word;

  modport source (output valid, digest_word, word_index, final_word, input ready);
  modport sink   (input valid, digest_word, word_index, final_word, output ready);
endinterface

[rtl/core/sha1_ram.sv]
// generic ram, one write port and two registered read ports
`timescale 1ns / 1ps
module sha1_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] ra_addr,
  input  logic [$clog2(DEPTH)-1:0] rb_addr,
  output logic [WIDTH-1:0]         ra_data,
  output logic [WIDTH-1:0]         rb_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    ra_data <= mem[ra_addr];
    rb_data <= mem[rb_addr];
  end

endmodule

[rtl/core/sha1_round.sv]
// sha1 round datapath: working words a..e and chaining words
`timescale 1ns / 1ps
module sha1_round (
  input  logic              clk,
  input  logic              rst_n,
  input  sha1_pkg::rnd_ctl_t ctl,
  input  sha1_pkg::word_t   w,
  output sha1_pkg::chain_t  chain
);

  sha1_pkg::chain_t chain_r;
  sha1_pkg::chain_t work_r;
  sha1_pkg::word_t  f;
  sha1_pkg::word_t  k;
  sha1_pkg::word_t  t;

  assign chain = chain_r;

  // round function and constant by round group
  always_comb begin
    if (ctl.rnd < sha1_pkg::RND_F1) begin
      f = (work_r[1] & work_r[2]) | (~work_r[1] & work_r[3]);
      k = sha1_pkg::K0;
    end else if (ctl.rnd < sha1_pkg::RND_F2) begin
      f = work_r[1] ^ work_r[2] ^ work_r[3];
      k = sha1_pkg::K1;
    end else if (ctl.rnd < sha1_pkg::RND_F3) begin
      f = (work_r[1] & work_r[2]) | (work_r[1] & work_r[3]) | (work_r[2] & work_r[3]);
      k = sha1_pkg::K2;
    end else begin
      f = work_r[1] ^ work_r[2] ^ work_r[3];
      k = sha1_pkg::K3;
    end
    t = sha1_pkg::rotl(work_r[0], 5) + f + work_r[4] + k + w;
  end

  // chaining words
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_r <= sha1_pkg::IV;
    end else if (ctl.iv) begin
      chain_r <= sha1_pkg::IV;
    end else if (ctl.fin) begin
      for (int i = 0; i < 5; i++) begin
        chain_r[i] <= chain_r[i] + work_r[i];
      end
    end
  end

  // working words
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      work_r <= chain_r;
    end else if (ctl.step) begin
      work_r[0] <= t;
      work_r[1] <= work_r[0];
      work_r[2] <= sha1_pkg::rotl(work_r[1], 30);
      work_r[3] <= work_r[2];
      work_r[4] <= work_r[3];
    end
  end

endmodule

[rtl/core/sha1_ctrl.sv]
// byte intake, padding, schedule memory sequencing and digest output
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sha1_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  sha1_in_if.sink             in_ch,
  sha1_out_if.source          out_ch,
  input  sha1_pkg::chain_t    chain,
  output sha1_pkg::rnd_ctl_t  rctl,
  output sha1_pkg::word_t     w_cur
);

  typedef enum logic [2:0] {
    S_LOAD,
    S_PAD,
    S_RND,
    S_FIN,
    S_DONE
  } state_t;

  state_t           state_r, state_nxt;
  logic [5:0]       fill_r, fill_nxt;
  logic [63:0]      bitlen_r, bitlen_nxt;
  logic             pad_act_r, pad_act_nxt;
  logic             pad_first_r, pad_first_nxt;
  logic             extra_r, extra_nxt;
  logic             pad_done_r, pad_done_nxt;
  logic [6:0]       rnd_r, rnd_nxt;
  logic             phase_r, phase_nxt;
  logic             out_busy_r, out_busy_nxt;
  logic [2:0]       out_idx_r, out_idx_nxt;

  logic [23:0]      pack_r;
  logic [63:0]      len_r;
  sha1_pkg::word_t  w0_r;
  sha1_pkg::word_t  x_r;
  sha1_pkg::chain_t dig_r;

  logic             in_fire;
  logic             in_last;
  logic             out_fire;
  logic             push_en;
  logic [7:0]       push_byte;
  logic             blk_done;
  logic [2:0]       len_sel;
  logic [7:0]       len_byte;

  logic                          sched_we;
  logic [sha1_pkg::SCHED_AW-1:0] sched_waddr;
  sha1_pkg::word_t               sched_wdata;
  logic [sha1_pkg::SCHED_AW-1:0] ra_addr;
  logic [sha1_pkg::SCHED_AW-1:0] rb_addr;
  sha1_pkg::word_t               ra_data;
  sha1_pkg::word_t               rb_data;

  // handshakes
  assign in_ch.ready = (state_r == S_LOAD);
  assign in_fire     = in_ch.valid & in_ch.ready;
  assign in_last     = in_ch.last;
  assign out_fire    = out_ch.valid & out_ch.ready;

  // digest beats
  assign out_ch.valid       = out_busy_r;
  assign out_ch.digest_word = dig_r[out_idx_r];
  assign out_ch.word_index  = out_idx_r;
  assign out_ch.final_word  = (out_idx_r == sha1_pkg::LAST_IDX);

  // padding byte: marker, zeros, then big-endian bit length
  assign len_sel  = 3'd7 - fill_r[2:0];
  assign len_byte = len_r[{len_sel, 3'b000} +: 8];

  always_comb begin
    push_en   = 1'b0;
    push_byte = sha1_pkg::PAD_ZERO;
    if (state_r == S_LOAD) begin
      push_en   = in_fire & in_ch.byte_present;
      push_byte = in_ch.data_byte;
    end else if (state_r == S_PAD) begin
      push_en = 1'b1;
      if (pad_first_r) begin
        push_byte = sha1_pkg::PAD_MARK;
      end else if (fill_r >= sha1_pkg::LEN_POS && !extra_r) begin
        push_byte = len_byte;
      end
    end
  end

  assign blk_done = push_en && (fill_r == sha1_pkg::FILL_LAST);

  // schedule word for the current round
  assign w_cur = (rnd_r < sha1_pkg::SCHED_WORDS) ? w0_r :
                 sha1_pkg::rotl(x_r ^ ra_data ^ rb_data, 1);

  // schedule memory port selection
  always_comb begin
    if (state_r == S_RND && phase_r) begin
      sched_we    = 1'b1;
      sched_waddr = rnd_r[sha1_pkg::SCHED_AW-1:0];
      sched_wdata = w_cur;
    end else begin
      sched_we    = push_en && (fill_r[1:0] == sha1_pkg::WORD_LAST);
      sched_waddr = fill_r[5:2];
      sched_wdata = {pack_r, push_byte};
    end
    if (state_r == S_RND && !phase_r) begin
      ra_addr = rnd_r[sha1_pkg::SCHED_AW-1:0] + sha1_pkg::OFS_M3;
      rb_addr = rnd_r[sha1_pkg::SCHED_AW-1:0] + sha1_pkg::OFS_M8;
    end else if (state_r == S_RND) begin
      ra_addr = rnd_r[sha1_pkg::SCHED_AW-1:0] + sha1_pkg::OFS_NEXT;
      rb_addr = rnd_r[sha1_pkg::SCHED_AW-1:0] + sha1_pkg::OFS_NEXT_M14;
    end else begin
      ra_addr = '0;
      rb_addr = sha1_pkg::OFS_M14;
    end
  end

  sha1_ram #(
    .WIDTH (32),
    .DEPTH (sha1_pkg::SCHED_DEPTH)
  ) u_sched_ram (
    .clk     (clk),
    .we      (sched_we),
    .waddr   (sched_waddr),
    .wdata   (sched_wdata),
    .ra_addr (ra_addr),
    .rb_addr (rb_addr),
    .ra_data (ra_data),
    .rb_data (rb_data)
  );

  // sequencer next state
  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    bitlen_nxt    = bitlen_r;
    pad_act_nxt   = pad_act_r;
    pad_first_nxt = pad_first_r;
    extra_nxt     = extra_r;
    pad_done_nxt  = pad_done_r;
    rnd_nxt       = rnd_r;
    phase_nxt     = phase_r;
    out_busy_nxt  = out_busy_r;
    out_idx_nxt   = out_idx_r;
    rctl          = '0;
    rctl.rnd      = rnd_r;

    if (push_en) begin
      fill_nxt = fill_r + 6'd1;
    end

    unique case (state_r)
      S_LOAD: begin
        if (in_fire) begin
          if (in_ch.byte_present) begin
            bitlen_nxt = bitlen_r + sha1_pkg::BITS_PER_BYTE;
          end
          if (in_last) begin
            pad_act_nxt   = 1'b1;
            pad_first_nxt = 1'b1;
            extra_nxt     = 1'b0;
            pad_done_nxt  = 1'b0;
          end
          if (blk_done) begin
            state_nxt = S_RND;
            rnd_nxt   = '0;
            phase_nxt = 1'b0;
            rctl.load = 1'b1;
          end else if (in_last) begin
            state_nxt = S_PAD;
          end
        end
      end
      S_PAD: begin
        pad_first_nxt = 1'b0;
        if (pad_first_r) begin
          extra_nxt = (fill_r >= sha1_pkg::LEN_POS);
        end
        if (blk_done) begin
          extra_nxt    = 1'b0;
          pad_done_nxt = !extra_r && !pad_first_r;
          state_nxt    = S_RND;
          rnd_nxt      = '0;
          phase_nxt    = 1'b0;
          rctl.load    = 1'b1;
        end
      end
      S_RND: begin
        phase_nxt = !phase_r;
        if (phase_r) begin
          rctl.step = 1'b1;
          rnd_nxt   = rnd_r + 7'd1;
          if (rnd_r == sha1_pkg::RND_LAST) begin
            state_nxt = S_FIN;
          end
        end
      end
      S_FIN: begin
        rctl.fin = 1'b1;
        if (pad_done_r) begin
          state_nxt = S_DONE;
        end else if (pad_act_r) begin
          state_nxt = S_PAD;
        end else begin
          state_nxt = S_LOAD;
        end
      end
      S_DONE: begin
        if (!out_busy_r) begin
          rctl.iv       = 1'b1;
          out_busy_nxt  = 1'b1;
          out_idx_nxt   = '0;
          bitlen_nxt    = '0;
          pad_act_nxt   = 1'b0;
          pad_first_nxt = 1'b0;
          extra_nxt     = 1'b0;
          pad_done_nxt  = 1'b0;
          state_nxt     = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase

    // digest beats drain independently of the sequencer
    if (out_fire) begin
      if (out_idx_r == sha1_pkg::LAST_IDX) begin
        out_busy_nxt = 1'b0;
      end else begin
        out_idx_nxt = out_idx_r + 3'd1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      fill_r      <= '0;
      bitlen_r    <= '0;
      pad_act_r   <= 1'b0;
      pad_first_r <= 1'b0;
      extra_r     <= 1'b0;
      pad_done_r  <= 1'b0;
      rnd_r       <= '0;
      phase_r     <= 1'b0;
      out_busy_r  <= 1'b0;
      out_idx_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      bitlen_r    <= bitlen_nxt;
      pad_act_r   <= pad_act_nxt;
      pad_first_r <= pad_first_nxt;
      extra_r     <= extra_nxt;
      pad_done_r  <= pad_done_nxt;
      rnd_r       <= rnd_nxt;
      phase_r     <= phase_nxt;
      out_busy_r  <= out_busy_nxt;
      out_idx_r   <= out_idx_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (push_en) begin
      pack_r <= {pack_r[15:0], push_byte};
    end
    if (state_r == S_LOAD && in_fire && in_last) begin
      len_r <= bitlen_nxt;
    end
    if (state_r == S_RND && !phase_r) begin
      w0_r <= ra_data;
      x_r  <= ra_data ^ rb_data;
    end
    if (state_r == S_DONE && !out_busy_r) begin
      dig_r <= chain;
    end
  end

  // checks
  `SHA_ASSERT(a_rnd_block_aligned, clk, rst_n, $rose(state_r == S_RND) |-> (fill_r == 6'd0))
  `SHA_ASSERT_NEXT(a_last_starts_pad, clk, rst_n, in_fire && in_last, pad_act_r)
  `SHA_ASSERT(a_done_after_pad, clk, rst_n, pad_done_r |-> (pad_act_r && !pad_first_r))
  `SHA_ASSERT_NEXT(a_final_beat_frees, clk, rst_n, out_fire && out_ch.final_word, !out_busy_r)

endmodule

[rtl/core/sha1_hash_engine_top.sv]
// top level of the sha1 hash engine
`timescale 1ns / 1ps
// SHA-1 engine taking one message byte per beat on in_ch and returning the
// 160-bit digest as five 32-bit beats on out_ch, most significant word first,
// after a beat with last set (byte_present may be 0 for an empty finish).
// The 64th byte of a block starts the compression, which holds in_ch off
// through 80 rounds, each split into a phase that reads two schedule words
// and a phase that reads two more and writes one, since the schedule memory
// gives two reads a cycle while a round needs four earlier schedule words,
// and then through S_FIN, which folds the round result into the chaining
// words. On last the engine pads on its own, one byte a cycle, through one
// or two more compressions, then moves the digest into the output buffer in
// S_DONE; the next message can stream in while the five digest beats drain,
// and a later digest waits only if that buffer is still busy.
module sha1_hash_engine_top (
  input  logic       clk,
  input  logic       rst_n,
  sha1_in_if.sink    in_ch,
  sha1_out_if.source out_ch
);

  sha1_pkg::rnd_ctl_t rctl;
  sha1_pkg::word_t    w_cur;
  sha1_pkg::chain_t   chain;

  sha1_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .chain  (chain),
    .rctl   (rctl),
    .w_cur  (w_cur)
  );

  sha1_round u_round (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (rctl),
    .w     (w_cur),
    .chain (chain)
  );

endmodule

[tb/sv/sha1_hash_engine_top_test.sv]
// testbench of the sha1 hash engine: byte messages checked against a digest predictor
`timescale 1ns / 1ps
module sha1_hash_engine_top_test;

  localparam int unsigned IDLE_LIMIT   = 6000;
  localparam int unsigned DRAIN_CYCLES = 500;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned DIGEST_WORDS = 5;
  localparam int unsigned BLOCK_BYTES  = 64;
  localparam int unsigned LENGTH_AT    = 56;
  localparam logic [7:0]  PAD_MARK     = 8'h80;
  localparam logic [7:0]  PAD_ZERO     = 8'h00;

  localparam logic [0:4][31:0] SHA1_IV = {32'h67452301, 32'hEFCDAB89, 32'h98BADCFE,
                                          32'h10325476, 32'hC3D2E1F0};
  localparam logic [0:3][31:0] ROUND_K = {32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC,
                                          32'hCA62C1D6};
  // digest of the empty message
  localparam logic [0:4][31:0] EMPTY_DIGEST = {32'hDA39A3EE, 32'h5E6B4B0D, 32'h3255BFEF,
                                               32'h95601890, 32'hAFD80709};

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        fin;
  } digest_beat_t;

  // directed beats; empty_ref marks a finish whose digest is the empty one
  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       lst;
    logic       empty_ref;
  } stim_row_t;

  localparam int N_ROWS = 15;

  logic clk;
  logic rst_n;

  sha1_in_if  in_ch ();
  sha1_out_if out_ch ();

  sha1_hash_engine_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  stim_row_t stim_rows [N_ROWS] = '{
    '{8'h00, 1'b0, 1'b1, 1'b1},  // empty message straight after reset
    '{8'hFF, 1'b0, 1'b0, 1'b0},  // empty step
    '{8'h61, 1'b1, 1'b0, 1'b0},
    '{8'h62, 1'b1, 1'b0, 1'b0},
    '{8'hA5, 1'b0, 1'b0, 1'b0},  // empty step inside a message
    '{8'h63, 1'b1, 1'b1, 1'b0},  // "abc", last on the byte
    '{8'h00, 1'b0, 1'b1, 1'b1},  // empty message right after a digest
    '{8'hFF, 1'b1, 1'b1, 1'b0},
    '{8'h00, 1'b1, 1'b1, 1'b0},
    '{8'h00, 1'b1, 1'b0, 1'b0},
    '{8'hFF, 1'b1, 1'b0, 1'b0},
    '{8'h5A, 1'b0, 1'b0, 1'b0},
    '{8'h00, 1'b0, 1'b1, 1'b0},  // empty finish after bytes
    '{8'h80, 1'b1, 1'b0, 1'b0},
    '{8'h7F, 1'b1, 1'b1, 1'b0}
  };

  // predictor state
  logic [31:0] chain [DIGEST_WORDS];
  logic [7:0]  block_buf [BLOCK_BYTES];
  int unsigned block_fill;
  logic [63:0] msg_bits;

  digest_beat_t pending_words [$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned items_sent;
  int unsigned bytes_sent;
  int unsigned messages;
  int unsigned words_checked;
  int unsigned mismatches;
  int unsigned idle_cycles;

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic logic [31:0] rol32(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic void clear_hash();
    for (int i = 0; i < DIGEST_WORDS; i++) chain[i] = SHA1_IV[i];
    block_fill = 0;
    msg_bits   = '0;
  endfunction

  // 80-round compression of the full block into the chaining words
  function automatic void compress_block();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int r = 0; r < 16; r++)
      w[r] = {block_buf[4*r], block_buf[4*r+1], block_buf[4*r+2], block_buf[4*r+3]};
    for (int r = 16; r < 80; r++)
      w[r] = rol32(w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16], 1);
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
    for (int r = 0; r < 80; r++) begin
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = ROUND_K[0];
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = ROUND_K[1];
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = ROUND_K[2];
      end else begin
        f = b ^ c ^ d;
        k = ROUND_K[3];
      end
      t = rol32(a, 5) + f + e + k + w[r];
      e = d; d = c; c = rol32(b, 30); b = a; a = t;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
  endfunction

  function automatic void absorb_byte(input logic [7:0] v);
    block_buf[block_fill] = v;
    block_fill++;
    if (block_fill == BLOCK_BYTES) begin
      compress_block();
      block_fill = 0;
    end
  endfunction

  // advance the predictor by one accepted beat, queue the digest on last
  function automatic void hash_beat(input logic [7:0] data, input logic present,
                                    input logic lst, input logic empty_ref);
    logic [63:0]  len;
    digest_beat_t beat;
    if (present) begin
      absorb_byte(data);
      msg_bits += 64'd8;
    end
    if (!lst) return;
    len = msg_bits;
    absorb_byte(PAD_MARK);
    while (block_fill != LENGTH_AT) absorb_byte(PAD_ZERO);
    for (int i = 7; i >= 0; i--) absorb_byte(len[8*i +: 8]);
    for (int i = 0; i < DIGEST_WORDS; i++) begin
      beat.word  = empty_ref ? EMPTY_DIGEST[i] : chain[i];
      beat.index = 3'(i);
      beat.fin   = (i == DIGEST_WORDS - 1);
      pending_words.push_back(beat);
    end
    clear_hash();
  endfunction

  // one beat on the byte channel, with a random gap ahead of it
  task automatic send_beat(input logic [7:0] data, input logic present, input logic lst,
                           input logic empty_ref);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.data_byte    <= data;
    in_ch.byte_present <= present;
    in_ch.last         <= lst;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    hash_beat(data, present, lst, empty_ref);
    if (present || lst) items_sent++;
    if (present) bytes_sent++;
  endtask

  // random message content, empty steps sprinkled in as noise
  task automatic send_message(input int unsigned n_bytes);
    logic tail_on_byte;
    tail_on_byte = (n_bytes != 0) && ($urandom_range(1) == 1);
    for (int unsigned i = 0; i < n_bytes; i++) begin
      if ($urandom_range(9) == 0) send_beat(8'($urandom_range(255)), 1'b0, 1'b0, 1'b0);
      send_beat(8'($urandom_range(255)), 1'b1, tail_on_byte && (i == n_bytes - 1), 1'b0);
    end
    if (!tail_on_byte) send_beat(8'($urandom_range(255)), 1'b0, 1'b1, 1'b0);
    messages++;
  endtask

  // hold the sender off until every digest word has come back
  task automatic wait_for_digests();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: digest %s mismatch, expected %h, got %h", $realtime, name, want, got);
    end
  endtask

  // receiver stalls
  always @(posedge clk) begin
    out_ch.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  // compare each digest beat with the oldest expected word
  always @(posedge clk) begin
    digest_beat_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      words_checked++;
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected digest beat, word %h index %0d", $realtime,
                   out_ch.digest_word, out_ch.word_index);
      end else begin
        want = pending_words.pop_front();
        check_field("word", want.word, out_ch.digest_word);
        check_field("index", 32'(want.index), 32'(out_ch.word_index));
        check_field("final flag", 32'(want.fin), 32'(out_ch.final_word));
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("timeout after %0d cycles with no beat", IDLE_LIMIT);
      $display("sha1_hash_engine_top_test NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned n_bytes;
    int unsigned ph_start;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.data_byte    = '0;
    in_ch.byte_present = 1'b0;
    in_ch.last         = 1'b0;
    send_idle_pct      = 24;
    recv_idle_pct      = 78;
    items_sent         = 0;
    bytes_sent         = 0;
    messages           = 0;
    clear_hash();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    for (int i = 0; i < N_ROWS; i++)
      send_beat(stim_rows[i].data, stim_rows[i].present, stim_rows[i].lst,
                stim_rows[i].empty_ref);

    // random messages over three idle settings
    for (int ph = 0; ph < 3; ph++) begin
      wait_for_digests();
      case (ph)
        0: begin
          send_idle_pct = 24;
          recv_idle_pct = 78;
        end
        1: begin
          send_idle_pct = 78;
          recv_idle_pct = 24;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      ph_start = items_sent;
      while (items_sent - ph_start < 20) begin
        // mostly short messages, some around the padding and block edges
        case ($urandom_range(19))
          0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11:
            n_bytes = $urandom_range(8);
          12, 13, 14, 15, 16:
            n_bytes = 64 * $urandom_range(1) + 55 + $urandom_range(10);
          default:
            n_bytes = $urandom_range(70);
        endcase
        send_message(n_bytes);
      end
    end

    wait_for_digests();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d messages, %0d message bytes, %0d beats with data or last",
             messages + 7, bytes_sent, items_sent);
    $display("%0d digest words checked, %0d mismatches", words_checked, mismatches);
    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("sha1_hash_engine_top_test OK");
    end else begin
      $display("sha1_hash_engine_top_test NOT OK");
    end
    $finish;
  end

endmodule

[sha1_hash_engine_top.f]
+incdir+rtl/core
rtl/core/sha1_pkg.sv
rtl/core/sha1_in_if.sv
rtl/core/sha1_out_if.sv
rtl/core/sha1_ram.sv
rtl/core/sha1_round.sv
rtl/core/sha1_ctrl.sv
rtl/core/sha1_hash_engine_top.sv
tb/sv/sha1_hash_engine_top_test.sv
